### src/erle_pkg.sv
package erle_pkg;

    // block store geometry
    localparam int BLOCK_ENTRIES = 256;
    localparam int BLOCK_AW      = $clog2(BLOCK_ENTRIES);
    localparam int ENTRY_W       = 16;

    // escape code after reset
    localparam logic [7:0] ESC_RESET = 8'hFF;

    // decoder phases
    localparam logic [3:0] PH_PLAIN  = 4'd0;
    localparam logic [3:0] PH_COUNT  = 4'd1;
    localparam logic [3:0] PH_ESC    = 4'd2;
    localparam logic [3:0] PH_CMD    = 4'd3;
    localparam logic [3:0] PH_NEWESC = 4'd4;
    localparam logic [3:0] PH_PASSES = 4'd5;
    localparam logic [3:0] PH_BLKLEN = 4'd6;
    localparam logic [3:0] PH_BLKVAL = 4'd7;
    localparam logic [3:0] PH_BLKCNT = 4'd8;
    localparam logic [3:0] PH_REPLAY = 4'd9;

    // commands after an escape pair
    localparam logic [7:0] CMD_END     = 8'd0;
    localparam logic [7:0] CMD_NEW_ESC = 8'd1;
    localparam logic [7:0] CMD_BLOCK   = 8'd2;

    // action codes
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // one result item
    typedef struct packed {
        logic       run_valid;
        logic [7:0] run_value;
        logic [8:0] run_length;
        logic       end_of_stream;
        logic       bad_command;
        logic       replay_busy;
        logic       dropped_input;
    } erle_result_t;

    // count byte to length, zero means 256
    function automatic logic [8:0] len_of(input logic [7:0] c);
        len_of = {(c == 8'd0), c};
    endfunction

endpackage

### src/erle_ram.sv
module erle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/escape_rle_run_decoder_top.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    action, data_byte
// output    out        out_valid / out_stall  run_valid, run_value, run_length,
//                                             end_of_stream, bad_command,
//                                             replay_busy, dropped_input
// config    in         cfg_write              cfg_data (initial escape)
//
// one item per cycle sustained while out_stall is low; an item is held in the input
// register and then decoded into the result register.
// the block store is a 256 x 16 ram; its read address is prefetched from the
// next replay position so a replay tick finds its entry already read.
// reset is asynchronous and clears all control state; no clearing pass.
// a stalled output holds its item, the input register keeps one more item,
// and in_stall rises only when both are full.
module escape_rle_run_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       run_valid,
    output logic [7:0] run_value,
    output logic [8:0] run_length,
    output logic       end_of_stream,
    output logic       bad_command,
    output logic       replay_busy,
    output logic       dropped_input
);

    // input register
    logic       st_valid_reg;
    logic       st_action_reg;
    logic [7:0] st_byte_reg;

    // decoder state
    logic [3:0] phase_reg, phase_next;
    logic [7:0] init_esc_reg;
    logic [7:0] escape_reg, escape_next;
    logic       count_mode_reg, count_mode_next;
    logic [7:0] held_reg, held_next;
    logic [8:0] passes_reg, passes_next;
    logic [8:0] blk_len_reg, blk_len_next;
    logic [8:0] fill_pos_reg, fill_pos_next;
    logic [erle_pkg::BLOCK_AW-1:0] replay_pos_reg, replay_pos_next;
    logic       stream_start_reg, stream_start_next;

    // result register
    logic                  out_valid_reg;
    erle_pkg::erle_result_t res_reg, res_next;
    logic                  has_result;

    // store ports
    logic                              ram_we;
    logic [erle_pkg::BLOCK_AW-1:0]     ram_waddr;
    logic [erle_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [erle_pkg::ENTRY_W-1:0]      ram_rdata;
    logic                              byp_valid_reg;
    logic [erle_pkg::ENTRY_W-1:0]      byp_data_reg;
    logic [erle_pkg::ENTRY_W-1:0]      entry;

    logic       advance;
    logic       in_take;
    logic [8:0] fill_inc;
    logic [8:0] replay_inc;
    logic [8:0] passes_dec;
    logic [7:0] entry_val;
    logic [7:0] entry_cnt;
    logic       entry_done;

    // handshake
    assign advance  = st_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = st_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            st_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            st_action_reg <= action;
            st_byte_reg   <= data_byte;
        end
    end

    // store entry seen by a replay tick, with write bypass
    assign entry = byp_valid_reg ? byp_data_reg : ram_rdata;

    assign fill_inc   = fill_pos_reg + 9'd1;
    assign replay_inc = {1'b0, replay_pos_reg} + 9'd1;
    assign passes_dec = passes_reg - 9'd1;

    // decode one item
    always_comb
    begin
        phase_next        = phase_reg;
        escape_next       = escape_reg;
        count_mode_next   = count_mode_reg;
        held_next         = held_reg;
        passes_next       = passes_reg;
        blk_len_next      = blk_len_reg;
        fill_pos_next     = fill_pos_reg;
        replay_pos_next   = replay_pos_reg;
        stream_start_next = stream_start_reg;
        res_next          = '0;
        ram_we            = 1'b0;
        ram_waddr         = fill_pos_reg[erle_pkg::BLOCK_AW-1:0];
        entry_val         = st_byte_reg;
        entry_cnt         = 8'd1;
        entry_done        = 1'b0;

        if (advance)
        begin
            if (phase_reg == erle_pkg::PH_REPLAY)
            begin
                if (st_action_reg == erle_pkg::ACT_DATA)
                begin
                    res_next.dropped_input = 1'b1;
                end
                else
                begin
                    res_next.run_valid  = 1'b1;
                    res_next.run_value  = entry[15:8];
                    res_next.run_length = erle_pkg::len_of(entry[7:0]);
                    if (replay_inc >= blk_len_reg)
                    begin
                        replay_pos_next = '0;
                        passes_next     = passes_dec;
                        if (passes_dec == 9'd0)
                        begin
                            phase_next = erle_pkg::PH_PLAIN;
                        end
                    end
                    else
                    begin
                        replay_pos_next = replay_inc[erle_pkg::BLOCK_AW-1:0];
                    end
                end
            end
            else if (st_action_reg == erle_pkg::ACT_DATA)
            begin
                stream_start_next = 1'b0;
                case (phase_reg)
                    erle_pkg::PH_PLAIN:
                    begin
                        if (st_byte_reg != escape_reg)
                        begin
                            if (count_mode_reg)
                            begin
                                held_next  = st_byte_reg;
                                phase_next = erle_pkg::PH_COUNT;
                            end
                            else
                            begin
                                res_next.run_valid  = 1'b1;
                                res_next.run_value  = st_byte_reg;
                                res_next.run_length = 9'd1;
                            end
                        end
                        else
                        begin
                            phase_next = erle_pkg::PH_ESC;
                        end
                    end
                    erle_pkg::PH_COUNT:
                    begin
                        res_next.run_valid  = 1'b1;
                        res_next.run_value  = held_reg;
                        res_next.run_length = erle_pkg::len_of(st_byte_reg);
                        phase_next          = erle_pkg::PH_PLAIN;
                    end
                    erle_pkg::PH_ESC:
                    begin
                        if (st_byte_reg != escape_reg)
                        begin
                            // toggle count mode, then a literal in the new mode
                            count_mode_next = !count_mode_reg;
                            if (!count_mode_reg)
                            begin
                                held_next  = st_byte_reg;
                                phase_next = erle_pkg::PH_COUNT;
                            end
                            else
                            begin
                                res_next.run_valid  = 1'b1;
                                res_next.run_value  = st_byte_reg;
                                res_next.run_length = 9'd1;
                                phase_next          = erle_pkg::PH_PLAIN;
                            end
                        end
                        else
                        begin
                            phase_next = erle_pkg::PH_CMD;
                        end
                    end
                    erle_pkg::PH_CMD:
                    begin
                        if (st_byte_reg == erle_pkg::CMD_NEW_ESC)
                        begin
                            phase_next = erle_pkg::PH_NEWESC;
                        end
                        else if (st_byte_reg == erle_pkg::CMD_BLOCK)
                        begin
                            phase_next = erle_pkg::PH_PASSES;
                        end
                        else
                        begin
                            // end of stream, clean or with an error
                            res_next.end_of_stream = (st_byte_reg == erle_pkg::CMD_END);
                            res_next.bad_command   = (st_byte_reg != erle_pkg::CMD_END);
                            phase_next        = erle_pkg::PH_PLAIN;
                            escape_next       = init_esc_reg;
                            count_mode_next   = 1'b0;
                            stream_start_next = 1'b1;
                        end
                    end
                    erle_pkg::PH_NEWESC:
                    begin
                        escape_next = st_byte_reg;
                        phase_next  = erle_pkg::PH_PLAIN;
                    end
                    erle_pkg::PH_PASSES:
                    begin
                        passes_next = erle_pkg::len_of(st_byte_reg);
                        phase_next  = erle_pkg::PH_BLKLEN;
                    end
                    erle_pkg::PH_BLKLEN:
                    begin
                        blk_len_next  = erle_pkg::len_of(st_byte_reg);
                        fill_pos_next = 9'd0;
                        phase_next    = erle_pkg::PH_BLKVAL;
                    end
                    erle_pkg::PH_BLKVAL:
                    begin
                        if (count_mode_reg)
                        begin
                            held_next  = st_byte_reg;
                            phase_next = erle_pkg::PH_BLKCNT;
                        end
                        else
                        begin
                            entry_val  = st_byte_reg;
                            entry_cnt  = 8'd1;
                            entry_done = 1'b1;
                        end
                    end
                    erle_pkg::PH_BLKCNT:
                    begin
                        entry_val  = held_reg;
                        entry_cnt  = st_byte_reg;
                        entry_done = 1'b1;
                    end
                    default:
                    begin
                        phase_next = erle_pkg::PH_PLAIN;
                    end
                endcase

                // block value complete: emit, store, step the fill
                if (entry_done)
                begin
                    res_next.run_valid  = 1'b1;
                    res_next.run_value  = entry_val;
                    res_next.run_length = erle_pkg::len_of(entry_cnt);
                    ram_we              = 1'b1;
                    fill_pos_next       = fill_inc;
                    if (fill_inc >= blk_len_reg)
                    begin
                        passes_next = passes_dec;
                        if (passes_dec == 9'd0)
                        begin
                            phase_next = erle_pkg::PH_PLAIN;
                        end
                        else
                        begin
                            replay_pos_next = '0;
                            phase_next      = erle_pkg::PH_REPLAY;
                        end
                    end
                    else
                    begin
                        phase_next = erle_pkg::PH_BLKVAL;
                    end
                end
            end
        end

        res_next.replay_busy = (phase_next == erle_pkg::PH_REPLAY);
        ram_wdata  = {entry_val, entry_cnt};
        has_result = res_next.run_valid || res_next.end_of_stream
                     || res_next.bad_command || res_next.dropped_input;
    end

    // block store, read address follows the next replay position
    erle_ram #(
        .WIDTH (erle_pkg::ENTRY_W),
        .DEPTH (erle_pkg::BLOCK_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (replay_pos_next),
        .rdata (ram_rdata)
    );

    // bypass for a write to the address being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= ram_we && (ram_waddr == replay_pos_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
    end

    // decoder state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= erle_pkg::PH_PLAIN;
            init_esc_reg     <= erle_pkg::ESC_RESET;
            escape_reg       <= erle_pkg::ESC_RESET;
            count_mode_reg   <= 1'b0;
            held_reg         <= 8'd0;
            passes_reg       <= 9'd0;
            blk_len_reg      <= 9'd0;
            fill_pos_reg     <= 9'd0;
            replay_pos_reg   <= '0;
            stream_start_reg <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            count_mode_reg   <= count_mode_next;
            held_reg         <= held_next;
            passes_reg       <= passes_next;
            blk_len_reg      <= blk_len_next;
            fill_pos_reg     <= fill_pos_next;
            replay_pos_reg   <= replay_pos_next;
            stream_start_reg <= stream_start_next;
            if (cfg_write)
            begin
                init_esc_reg <= cfg_data;
            end
            if (cfg_write && stream_start_reg)
            begin
                escape_reg <= cfg_data;
            end
            else
            begin
                escape_reg <= escape_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= has_result;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign run_valid     = res_reg.run_valid;
    assign run_value     = res_reg.run_value;
    assign run_length    = res_reg.run_length;
    assign end_of_stream = res_reg.end_of_stream;
    assign bad_command   = res_reg.bad_command;
    assign replay_busy   = res_reg.replay_busy;
    assign dropped_input = res_reg.dropped_input;

    // a run never has zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.run_valid |-> res_reg.run_length != 9'd0)
        else $error("run with zero length");

    // a discarded byte only happens while a replay is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.dropped_input |-> res_reg.replay_busy)
        else $error("dropped byte outside replay");

    // replay always has passes left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == erle_pkg::PH_REPLAY |-> passes_reg != 9'd0)
        else $error("replay with no passes left");

    // filling stays inside the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == erle_pkg::PH_BLKVAL || phase_reg == erle_pkg::PH_BLKCNT)
        |-> fill_pos_reg < blk_len_reg)
        else $error("fill position past block length");

endmodule
